@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ src/pcfd_pkg.sv @@
// ----------------------------------------------------------------------------
// PID controller package
// Types, constants and fixed-point helper functions of the PID core.
// ----------------------------------------------------------------------------
`default_nettype none
package pcfd_pkg;

  localparam int DW       = 32;
  localparam int FB       = 16;
  localparam int WB       = 16;
  localparam int DRIVE_W  = 23;
  localparam int DIV_W    = DW + FB;
  localparam logic [16:0] W_ONE = 17'd65536;
  localparam logic signed [33:0] DRIVE_MAX = 34'sd6553600;

  typedef enum logic [2:0] {
    REG_SETPOINT  = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_INT_LIMIT = 3'd4,
    REG_FILT_W    = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_ERR,
    OP_MUL_INT,
    OP_INTEG,
    OP_DIV,
    OP_MUL_RAW,
    OP_MUL_FILT,
    OP_DERIV,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_TOTAL,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic signed [DW-1:0] sat34(input logic signed [33:0] v);
    logic signed [DW-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] r;
    r = v[DW-1] ? (~v + 32'd1) : v;
    return r;
  endfunction

  function automatic logic signed [DW-1:0] fin(input logic [63:0] p, input logic neg);
    logic [47:0] s;
    logic signed [DW-1:0] r;
    s = p[63:FB];
    if (s > 48'h0000_7FFF_FFFF) begin
      r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = neg ? -$signed(s[DW-1:0]) : $signed(s[DW-1:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/pid_clamped_integral_filtered_derivative_core.sv @@
// ----------------------------------------------------------------------------
// PID controller core
// Q16.16 PID step with clamped integral and filtered derivative.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       sink       in_valid/in_stall  action, measurement, time_step
// out      source     out_valid/out_stall drive, step_fault
// cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// A compute item runs through the 48-step serial divider and makes six
// passes through the shared 32x32 multiplier; a zero time step skips the
// divider and the two filter passes. A clear item stays in the idle state.
// Reset restores the register defaults and zeroes the controller state.
// A finished result waits in the output register while out_stall is high.
`default_nettype none
module pid_clamped_integral_filtered_derivative_core
  import pcfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [DW-1:0]        cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 action,
  input  wire logic signed [DW-1:0] measurement,
  input  wire logic [DW-1:0]        time_step,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [DRIVE_W-1:0]        drive,
  output logic                      step_fault
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  pcfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pcfd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .measurement (measurement),
    .time_step   (time_step),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .drive       (drive),
    .step_fault  (step_fault)
  );

endmodule
`default_nettype wire

@@ src/pcfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps the datapath through error, integral, divide, filter and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pcfd_ctrl
  import pcfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    action,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_MINT, S_INTEG, S_DIV, S_MRAW, S_MFILT, S_DERIV,
    S_MP, S_MI, S_MD, S_TOT, S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = action ? OP_CLEAR : OP_LOAD;
          if (!action) state_next = S_ERR;
        end
      end
      S_ERR: begin cmd.op = OP_ERR; state_next = S_MINT; end
      S_MINT: begin cmd.op = OP_MUL_INT; state_next = S_INTEG; end
      S_INTEG: begin
        cmd.op = OP_INTEG;
        state_next = status.dt_zero ? S_MP : S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (status.div_last) state_next = S_MRAW;
      end
      S_MRAW: begin cmd.op = OP_MUL_RAW; state_next = S_MFILT; end
      S_MFILT: begin cmd.op = OP_MUL_FILT; state_next = S_DERIV; end
      S_DERIV: begin cmd.op = OP_DERIV; state_next = S_MP; end
      S_MP: begin cmd.op = OP_MUL_P; state_next = S_MI; end
      S_MI: begin cmd.op = OP_MUL_I; state_next = S_MD; end
      S_MD: begin cmd.op = OP_MUL_D; state_next = S_TOT; end
      S_TOT: begin cmd.op = OP_TOTAL; state_next = S_DONE; end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op = OP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_CLK(a_div_exit, clk, rst, (state == S_DIV && status.div_last) |=> state == S_MRAW)
  `ASSERT_CLK(a_done_exit, clk, rst, (state == S_DONE && status.out_free) |=> state == S_IDLE)
  `ASSERT_CLK(a_compute_busy, clk, rst, (in_valid && !in_stall && !action) |=> in_stall)
  `ASSERT_CLK(a_clear_idle, clk, rst, (in_valid && !in_stall && action) |=> !in_stall)

endmodule
`default_nettype wire

@@ src/pcfd_datapath.sv @@
// ----------------------------------------------------------------------------
// PID controller datapath
// Configuration registers, state, shared multiplier and serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
module pcfd_datapath
  import pcfd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [DW-1:0]          cfg_data,
  input  wire logic signed [DW-1:0]   measurement,
  input  wire logic [DW-1:0]          time_step,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output logic [DRIVE_W-1:0]          drive,
  output logic                        step_fault
);

  logic signed [DW-1:0] setpoint;
  logic [DW-1:0]        gain_p, gain_i, gain_d;
  logic [30:0]          integral_limit;
  logic [16:0]          filter_weight;

  logic signed [DW-1:0] integral_sum, previous_error, filtered_derivative;
  logic signed [DW-1:0] meas, err, integ, deriv;
  logic [DW-1:0]        dt;
  logic [63:0]          prod;
  logic                 pneg;
  logic signed [33:0]   acc;
  logic [DW-1:0]        rem;
  logic [DIV_W-1:0]     quo;
  logic [5:0]           cnt;
  logic                 dneg;

  logic signed [DW-1:0] fp, diff, integ_sat, lim_pos, lim_neg;
  logic [16:0]          w_cap, w_rest;
  logic [DW:0]          trial;
  logic                 take;
  logic [DW-1:0]        raw_mag;

  always_comb begin
    fp        = fin(prod, pneg);
    diff      = sat34(34'(err) - 34'(previous_error));
    integ_sat = sat34(34'(integral_sum) + 34'(fp));
    lim_pos   = $signed({1'b0, integral_limit});
    lim_neg   = -lim_pos;
    w_cap     = (filter_weight > W_ONE) ? W_ONE : filter_weight;
    w_rest    = W_ONE - w_cap;
    trial     = {rem, quo[DIV_W-1]};
    take      = (trial >= {1'b0, dt});
    if (quo[DIV_W-1:DW-1] != '0) begin
      raw_mag = dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      raw_mag = quo[DW-1:0];
    end
  end

  assign status.dt_zero  = (dt == '0);
  assign status.div_last = (cnt == 6'(DIV_W - 1));
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= 32'sd1638400;
      gain_p         <= 32'd131072;
      gain_i         <= 32'd32768;
      gain_d         <= 32'd6554;
      integral_limit <= 31'd3276800;
      filter_weight  <= 17'd6554;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETPOINT:  setpoint       <= cfg_data;
        REG_GAIN_P:    gain_p         <= cfg_data;
        REG_GAIN_I:    gain_i         <= cfg_data;
        REG_GAIN_D:    gain_d         <= cfg_data;
        REG_INT_LIMIT: integral_limit <= cfg_data[30:0];
        REG_FILT_W:    filter_weight  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum        <= '0;
      previous_error      <= '0;
      filtered_derivative <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cmd.op == OP_COMMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: begin
          integral_sum        <= '0;
          previous_error      <= '0;
          filtered_derivative <= '0;
        end
        OP_COMMIT: begin
          integral_sum        <= integ;
          previous_error      <= err;
          filtered_derivative <= deriv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        meas <= measurement;
        dt   <= time_step;
      end
      OP_ERR: err <= sat34(34'(setpoint) - 34'(meas));
      OP_MUL_INT: begin
        prod <= 64'(mag(err)) * 64'(dt);
        pneg <= err[DW-1];
      end
      OP_INTEG: begin
        if (integ_sat > lim_pos) begin
          integ <= lim_pos;
        end else if (integ_sat < lim_neg) begin
          integ <= lim_neg;
        end else begin
          integ <= integ_sat;
        end
        dneg <= diff[DW-1];
        quo  <= {mag(diff), FB'(0)};
        rem  <= '0;
        cnt  <= '0;
        if (dt == '0) deriv <= filtered_derivative;
      end
      OP_DIV: begin
        rem <= take ? DW'(trial - {1'b0, dt}) : trial[DW-1:0];
        quo <= {quo[DIV_W-2:0], take};
        cnt <= cnt + 6'd1;
      end
      OP_MUL_RAW: begin
        prod <= 64'(raw_mag) * 64'(w_cap);
        pneg <= dneg;
      end
      OP_MUL_FILT: begin
        acc  <= 34'(fp);
        prod <= 64'(mag(filtered_derivative)) * 64'(w_rest);
        pneg <= filtered_derivative[DW-1];
      end
      OP_DERIV: deriv <= sat34(acc + 34'(fp));
      OP_MUL_P: begin
        prod <= 64'(mag(err)) * 64'(gain_p);
        pneg <= err[DW-1];
      end
      OP_MUL_I: begin
        acc  <= 34'(fp);
        prod <= 64'(mag(integ)) * 64'(gain_i);
        pneg <= integ[DW-1];
      end
      OP_MUL_D: begin
        acc  <= acc + 34'(fp);
        prod <= 64'(mag(deriv)) * 64'(gain_d);
        pneg <= deriv[DW-1];
      end
      OP_TOTAL: acc <= acc + 34'(fp);
      OP_COMMIT: begin
        if (acc < 0) begin
          drive <= '0;
        end else if (acc > DRIVE_MAX) begin
          drive <= DRIVE_MAX[DRIVE_W-1:0];
        end else begin
          drive <= acc[DRIVE_W-1:0];
        end
        step_fault <= (dt == '0);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ tb/tb_pid_clamped_integral_filtered_derivative_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller core testbench
// Drives compute and clear items through the core under several register
// settings and idling patterns, predicts each drive value and fault flag in
// Q16.16 fixed point, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_pid_clamped_integral_filtered_derivative_core;
  import pcfd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct {
    logic [DRIVE_W-1:0] drive;
    logic               fault;
  } pid_out_t;

  class pid_scoreboard;
    longint          setpoint;
    longint unsigned kp, ki, kd, limit, weight;
    longint          integ, prev_err, filt;
    pid_out_t        pending_q[$];
    int              errors, n_items, n_results, n_faults, n_clears;

    function new();
      setpoint = 1638400; kp = 131072; ki = 32768; kd = 6554;
      limit = 3276800; weight = 6554;
      integ = 0; prev_err = 0; filt = 0;
      errors = 0; n_items = 0; n_results = 0; n_faults = 0; n_clears = 0;
    endfunction

    function longint clip(longint v);
      return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
    endfunction

    function longint scale(longint a, longint unsigned b, int s);
      logic            neg;
      longint unsigned m, p;
      neg = a < 0;
      m = neg ? -a : a;
      p = (m * b) >> s;
      if (p > 64'd2147483647) return neg ? QMIN : QMAX;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_SETPOINT:  setpoint = longint'($signed(val));
        REG_GAIN_P:    kp = val;
        REG_GAIN_I:    ki = val;
        REG_GAIN_D:    kd = val;
        REG_INT_LIMIT: limit = val[30:0];
        REG_FILT_W:    weight = val[16:0];
        default: ;
      endcase
    endfunction

    function void note(logic act, logic signed [31:0] meas, logic [31:0] dt);
      longint          err, ig, dv, raw, total;
      longint unsigned w, q, m;
      pid_out_t        r;
      n_items++;
      if (act) begin
        integ = 0; prev_err = 0; filt = 0;
        n_clears++;
        return;
      end
      err = clip(setpoint - longint'(meas));
      ig = clip(integ + scale(err, dt, FB));
      if (ig > longint'(limit)) ig = limit;
      if (ig < -longint'(limit)) ig = -longint'(limit);
      if (dt == 0) begin
        r.fault = 1;
        dv = filt;
      end else begin
        r.fault = 0;
        raw = clip(err - prev_err);
        m = raw < 0 ? -raw : raw;
        q = (m << FB) / dt;
        if (q > 64'd2147483647) raw = raw < 0 ? QMIN : QMAX;
        else raw = raw < 0 ? -longint'(q) : longint'(q);
        w = weight > 65536 ? 65536 : weight;
        dv = clip(scale(raw, w, WB) + scale(filt, 65536 - w, WB));
      end
      integ = ig; prev_err = err; filt = dv;
      total = scale(err, kp, FB) + scale(ig, ki, FB) + scale(dv, kd, FB);
      if (total < 0) total = 0;
      if (total > 6553600) total = 6553600;
      r.drive = total[DRIVE_W-1:0];
      pending_q.push_back(r);
    endfunction

    function void check(logic [DRIVE_W-1:0] drv, logic flt);
      pid_out_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: drive %0d step_fault %0d", drv, flt);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      n_results++;
      if (flt) n_faults++;
      if (drv !== e.drive) begin
        $error("drive: expected %0d actual %0d", e.drive, drv);
        errors++;
      end
      if (flt !== e.fault) begin
        $error("step_fault: expected %0d actual %0d", e.fault, flt);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               action = 0;
  logic signed [31:0] measurement = '0;
  logic [31:0]        time_step = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [DRIVE_W-1:0] drive;
  logic               step_fault;

  pid_scoreboard sb = new();
  int idle_in = 0, idle_out = 0;
  int hold_cnt = 0;
  logic hold_req = 0, hold_done = 0;
  int cycles = 0;

  pid_clamped_integral_filtered_derivative_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .measurement(measurement), .time_step(time_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive(drive), .step_fault(step_fault)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note(action, measurement, time_step);
      if (out_valid && !out_stall) sb.check(drive, step_fault);
    end
  end

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cnt <= 400;
      hold_done <= 1;
      out_stall <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1;
    end else begin
      out_stall <= $urandom_range(99) < idle_out;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(reg_idx_t'(idx), val);
  endtask

  task automatic program_regs(logic [31:0] sp, logic [31:0] gp, logic [31:0] gi,
                              logic [31:0] gd, logic [31:0] lim, logic [31:0] fw);
    write_cfg(REG_SETPOINT, sp);
    write_cfg(REG_GAIN_P, gp);
    write_cfg(REG_GAIN_I, gi);
    write_cfg(REG_GAIN_D, gd);
    write_cfg(REG_INT_LIMIT, lim);
    write_cfg(REG_FILT_W, fw);
    write_cfg(3'd6, $urandom());
    write_cfg(3'd7, $urandom());
    cfg_valid <= 0;
  endtask

  task automatic send_item(logic act, logic [31:0] meas, logic [31:0] dt);
    if ($urandom_range(99) < idle_in) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_in) @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    measurement <= meas;
    time_step <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_items(int count);
    logic [31:0] meas, dt;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 60) meas = 32'(sb.setpoint + $signed($urandom_range(65536 * 8)) - 65536 * 4);
      else meas = $urandom();
      k = $urandom_range(99);
      if (k < 6) dt = 0;
      else if (k < 60) dt = $urandom_range(6554, 65536);
      else if (k < 75) dt = $urandom_range(1, 16);
      else if (k < 95) dt = $urandom();
      else dt = 32'hFFFF_FFFF;
      send_item($urandom_range(99) < 3, meas, dt);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_item(0, 32'h0019_0000, 32'h0000_1999);
    send_item(0, 32'h8000_0000, 32'h0001_0000);
    send_item(0, 32'h7FFF_FFFF, 32'h0001_0000);
    send_item(0, 32'h8000_0000, 32'h0000_0001);
    send_item(0, 32'h7FFF_FFFF, 32'h0000_0001);
    send_item(0, 32'h0010_0000, 32'h0000_0000);
    send_item(0, 32'h0000_0000, 32'h0000_0000);
    send_item(0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(1, 32'h1234_5678, 32'h0000_0000);
    send_item(0, 32'h0018_0000, 32'h0000_8000);
    send_item(0, 32'hFFFF_FFFF, 32'h0100_0000);
    send_item(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(0, 32'hFFF0_0000, 32'h0002_0000);
    settle();

    program_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'h0001_FFFF);
    send_item(0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(0, 32'h7FFF_FFFF, 32'h0000_0001);
    send_item(0, 32'h8000_0000, 32'h0000_0000);
    settle();
    program_regs(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(0, 32'h7FFF_FFFF, 32'h0001_0000);
    send_item(0, 32'h0, 32'h0000_0000);
    settle();

    idle_in = 29; idle_out = 84;
    program_regs(32'h0019_0000, 32'h0002_0000, 32'h0000_8000, 32'h0000_199A,
                 32'h0032_0000, 32'h0000_199A);
    random_items(225);
    settle();
    program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 32'h0001_0000);
    random_items(225);
    settle();

    idle_in = 84; idle_out = 29;
    program_regs($urandom(), $urandom_range(0, 32'h0010_0000),
                 $urandom_range(0, 32'h0001_0000), $urandom_range(0, 32'h0004_0000),
                 $urandom(), $urandom_range(0, 65536));
    random_items(225);
    settle();
    program_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
                 32'h7FFF_FFFF, 32'h0000_0000);
    random_items(225);
    settle();

    idle_in = 0; idle_out = 0;
    program_regs(32'h0032_0000, 32'h0001_0000, 32'h0000_4000, 32'h0000_8000,
                 32'h0064_0000, 32'h0000_8000);
    hold_req <= 1;
    random_items(225);
    settle();
    program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_items(225);
    settle();

    $display("Covered %0d items (%0d clears), %0d results, %0d with step fault.",
             sb.n_items, sb.n_clears, sb.n_results, sb.n_faults);
    $display("Settings included extreme gains, limits and filter weights.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
